### hw/rtl/fres_pkg.sv
// Package for the flash region erase sequencer: widths, codes, types and defaults.
package fres_pkg;

    // Field and register widths
    localparam int START_W    = 24;
    localparam int LEN_W      = 25;
    localparam int POLL_W     = 16;
    localparam int OP_W       = 8;
    localparam int ADDR_OUT_W = 24;
    localparam int OC_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int STATUS_W   = 8;

    // Default geometry (sizes must be powers of two)
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int BLOCK_BYTES_DEF  = 65536;
    localparam int ADDRESS_BITS_DEF = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [START_W-1:0] RST_REGION_START = 24'd73728;
    localparam logic [LEN_W-1:0]   RST_REGION_LEN   = 25'd819200;
    localparam logic [POLL_W-1:0]  RST_SECTOR_LIMIT = 16'd3000;
    localparam logic [POLL_W-1:0]  RST_BLOCK_LIMIT  = 16'd30000;

    // SPI opcodes
    localparam logic [OP_W-1:0] OP_NONE = 8'h00;
    localparam logic [OP_W-1:0] OP_WREN = 8'h06;
    localparam logic [OP_W-1:0] OP_RDSR = 8'h05;
    localparam logic [OP_W-1:0] OP_SE   = 8'h20;
    localparam logic [OP_W-1:0] OP_BE   = 8'hD8;

    // Status register bits
    localparam int SR_BUSY = 0;
    localparam int SR_WEL  = 1;

    // Item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Outcome codes
    localparam logic [OC_W-1:0] OC_RUN      = 3'd0;
    localparam logic [OC_W-1:0] OC_DONE     = 3'd1;
    localparam logic [OC_W-1:0] OC_WEL      = 3'd2;
    localparam logic [OC_W-1:0] OC_TIMEOUT  = 3'd3;
    localparam logic [OC_W-1:0] OC_MISALIGN = 3'd4;
    localparam logic [OC_W-1:0] OC_LEN      = 3'd5;
    localparam logic [OC_W-1:0] OC_UNEXP    = 3'd6;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WEL,
        PH_POLL
    } phase_t;

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_BLOCKS,
        ST_TAIL
    } stage_t;

    // What one accepted item makes the sequencer emit
    typedef enum logic [3:0] {
        ACT_UNEXP,
        ACT_WEL_FAIL,
        ACT_TIMEOUT,
        ACT_MISALIGN,
        ACT_DONE,
        ACT_LEN,
        ACT_NEXT_ERASE,
        ACT_ERASE_CMD,
        ACT_POLL
    } act_t;

    // One result item
    typedef struct packed {
        logic [OP_W-1:0]       opcode;
        logic [ADDR_OUT_W-1:0] address;
        logic                  has_address;
        logic                  wants_reply;
        logic                  last;
        logic [OC_W-1:0]       outcome;
        logic [LEN_W-1:0]      erased_bytes;
    } result_t;

endpackage

### hw/rtl/flash_region_erase_sequencer.sv
// Top level of the flash region erase sequencer: state update and result buffer.
//
//  Channel  Signals                                   Direction  Handshake
//  in       kind, status_byte                         to block   in_valid / in_stall
//  out      opcode, address, has_address,             from block out_valid / out_stall
//           wants_reply, last, outcome, erased_bytes
//  cfg      cfg_index, cfg_data                       to block   cfg_write
//
// An item is handled in the cycle it is accepted; its one or two results land in a
// two-entry result buffer and leave one per cycle while out_stall is low. Items that
// cause one result flow at one per cycle while out_stall is low; an item that causes
// two results holds off the next until its first result has left the single output
// port. A new item is taken while the last buffered result is being taken. Reset is
// asynchronous, clears control state and loads the configuration registers with
// their defaults; a stall on the output holds the buffer.
module flash_region_erase_sequencer #(
    parameter int SECTOR_BYTES = fres_pkg::SECTOR_BYTES_DEF,
    parameter int BLOCK_BYTES  = fres_pkg::BLOCK_BYTES_DEF,
    parameter int ADDRESS_BITS = fres_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [fres_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fres_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [fres_pkg::STATUS_W-1:0]       status_byte,
    // result items
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fres_pkg::OP_W-1:0]           opcode,
    output logic [fres_pkg::ADDR_OUT_W-1:0]     address,
    output logic                                has_address,
    output logic                                wants_reply,
    output logic                                last,
    output logic [fres_pkg::OC_W-1:0]           outcome,
    output logic [fres_pkg::LEN_W-1:0]          erased_bytes
);
    import fres_pkg::*;

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
    localparam int CNT_W        = LEN_W - SECTOR_SHIFT + 1;
    localparam int SUM_W        = (ADDRESS_BITS > LEN_W + 1) ? ADDRESS_BITS : LEN_W + 1;
    localparam logic [LEN_W-1:0] SECTOR_INC = LEN_W'(SECTOR_BYTES);
    localparam logic [LEN_W-1:0] BLOCK_INC  = LEN_W'(BLOCK_BYTES);

    // Configuration registers
    logic [START_W-1:0] region_start_reg;
    logic [LEN_W-1:0]   region_len_reg;
    logic [POLL_W-1:0]  sector_limit_reg;
    logic [POLL_W-1:0]  block_limit_reg;

    // Sequencer state
    phase_t                  phase_reg, phase_next;
    stage_t                  stage_reg, stage_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic [ADDRESS_BITS-1:0] cur_addr_reg, cur_addr_next;
    logic [POLL_W-1:0]       poll_reg, poll_next;
    logic [LEN_W-1:0]        erased_reg, erased_next;
    act_t                    act;

    // Result buffer
    result_t     slot0_reg, slot1_reg;
    logic [1:0]  cnt_reg;
    result_t     res0, res1;
    logic [1:0]  res_n;

    logic in_accept;
    logic out_pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_pop   = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall));
    assign in_accept = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= RST_REGION_START;
            region_len_reg   <= RST_REGION_LEN;
            sector_limit_reg <= RST_SECTOR_LIMIT;
            block_limit_reg  <= RST_BLOCK_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REGION_START: region_start_reg <= cfg_data[START_W-1:0];
                REG_REGION_LEN:   region_len_reg   <= cfg_data[LEN_W-1:0];
                REG_SECTOR_LIMIT: sector_limit_reg <= cfg_data[POLL_W-1:0];
                REG_BLOCK_LIMIT:  block_limit_reg  <= cfg_data[POLL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Next state: step on the item, then walk the stages to the next erase or the end
    always_comb
    begin
        logic                   in_block;
        logic                   go_adv;
        logic                   fin;
        logic [POLL_W-1:0]      limit;
        logic [BLOCK_SHIFT-1:0] head_gap;
        logic [LEN_W-1:0]       rem;
        logic [SUM_W-1:0]       sum;
        logic                   misaligned;

        phase_next    = phase_reg;
        stage_next    = stage_reg;
        left_next     = left_reg;
        cur_addr_next = cur_addr_reg;
        poll_next     = poll_reg;
        erased_next   = erased_reg;
        act           = ACT_UNEXP;
        go_adv        = 1'b0;
        fin           = 1'b0;
        in_block      = (stage_reg == ST_BLOCKS);
        limit         = in_block ? block_limit_reg : sector_limit_reg;
        // distance from start to next block boundary, zero when aligned
        head_gap      = '0 - region_start_reg[BLOCK_SHIFT-1:0];

        if (kind == KIND_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                erased_next = '0;
                poll_next   = '0;
                stage_next  = ST_HEAD;
                left_next   = CNT_W'(head_gap >> SECTOR_SHIFT);
                go_adv      = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_WEL:
                begin
                    if (!status_byte[SR_WEL])
                    begin
                        act        = ACT_WEL_FAIL;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        act        = ACT_ERASE_CMD;
                        poll_next  = POLL_W'(1);
                        phase_next = PH_POLL;
                    end
                end
                PH_POLL:
                begin
                    if (!status_byte[SR_BUSY] && !status_byte[SR_WEL])
                    begin
                        erased_next = erased_reg + (in_block ? BLOCK_INC : SECTOR_INC);
                        left_next   = left_reg - CNT_W'(1);
                        poll_next   = '0;
                        go_adv      = 1'b1;
                    end
                    else if (poll_reg >= limit)
                    begin
                        act        = ACT_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        act       = ACT_POLL;
                        poll_next = poll_reg + POLL_W'(1);
                    end
                end
                default: act = ACT_UNEXP;
            endcase
        end

        // values the stage walk depends on, taken after the erased count update
        rem        = (region_len_reg > erased_next) ? region_len_reg - erased_next : '0;
        sum        = SUM_W'(region_start_reg) + SUM_W'(erased_next);
        misaligned = (sum[BLOCK_SHIFT-1:0] != '0);

        // stage walk: head, blocks, tail, end
        if (go_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!fin)
                begin
                    if (left_next != '0)
                    begin
                        act = ACT_NEXT_ERASE;
                        fin = 1'b1;
                    end
                    else
                    begin
                        case (stage_next)
                            ST_HEAD:
                            begin
                                if (misaligned)
                                begin
                                    act = ACT_MISALIGN;
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    stage_next = ST_BLOCKS;
                                    left_next  = CNT_W'(rem >> BLOCK_SHIFT);
                                end
                            end
                            ST_BLOCKS:
                            begin
                                stage_next = ST_TAIL;
                                left_next  = CNT_W'(rem >> SECTOR_SHIFT);
                            end
                            default:
                            begin
                                act = (erased_next == region_len_reg) ? ACT_DONE : ACT_LEN;
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            if (act == ACT_NEXT_ERASE)
            begin
                phase_next    = PH_WEL;
                cur_addr_next = sum[ADDRESS_BITS-1:0];
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Results for the action taken
    always_comb
    begin
        logic [SUM_W-1:0] addr_ext;

        addr_ext = SUM_W'(cur_addr_reg);

        res0              = '0;
        res0.last         = 1'b1;
        res0.erased_bytes = erased_next;
        res1              = '0;
        res1.opcode       = OP_RDSR;
        res1.wants_reply  = 1'b1;
        res1.last         = 1'b1;
        res1.outcome      = OC_RUN;
        res1.erased_bytes = erased_next;
        res_n             = 2'd1;

        case (act)
            ACT_NEXT_ERASE:
            begin
                res0.opcode = OP_WREN;
                res0.last   = 1'b0;
                res0.outcome = OC_RUN;
                res_n       = 2'd2;
            end
            ACT_ERASE_CMD:
            begin
                res0.opcode      = (stage_reg == ST_BLOCKS) ? OP_BE : OP_SE;
                res0.address     = addr_ext[ADDR_OUT_W-1:0];
                res0.has_address = 1'b1;
                res0.last        = 1'b0;
                res0.outcome     = OC_RUN;
                res_n            = 2'd2;
            end
            ACT_POLL:
            begin
                res0.opcode      = OP_RDSR;
                res0.wants_reply = 1'b1;
                res0.outcome     = OC_RUN;
            end
            ACT_WEL_FAIL: res0.outcome = OC_WEL;
            ACT_TIMEOUT:  res0.outcome = OC_TIMEOUT;
            ACT_MISALIGN: res0.outcome = OC_MISALIGN;
            ACT_DONE:     res0.outcome = OC_DONE;
            ACT_LEN:      res0.outcome = OC_LEN;
            default:      res0.outcome = OC_UNEXP;
        endcase
    end

    // Sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            stage_reg    <= ST_HEAD;
            left_reg     <= '0;
            cur_addr_reg <= '0;
            poll_reg     <= '0;
            erased_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            stage_reg    <= stage_next;
            left_reg     <= left_next;
            cur_addr_reg <= cur_addr_next;
            poll_reg     <= poll_next;
            erased_reg   <= erased_next;
        end
    end

    // Result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (in_accept)
        begin
            cnt_reg <= res_n;
        end
        else if (out_pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result buffer payload: new item fills from the head, a pop shifts forward
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign opcode       = slot0_reg.opcode;
    assign address      = slot0_reg.address;
    assign has_address  = slot0_reg.has_address;
    assign wants_reply  = slot0_reg.wants_reply;
    assign last         = slot0_reg.last;
    assign outcome      = slot0_reg.outcome;
    assign erased_bytes = slot0_reg.erased_bytes;

endmodule
